FILE: rtl/esps_pkg.sv
// esps_pkg: shared types, constants and the control store of the event stack
// with priority sort; no dependencies, compiled first
package esps_pkg;

	// field widths fixed by the interface
	localparam int unsigned ID_W      = 8;
	localparam int unsigned PRI_W     = 8;
	localparam int unsigned CNT_W     = 7;
	localparam int unsigned DEPTH_DEF = 64;
	localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

	// operation codes
	typedef enum logic [1:0] {
		KIND_PUSH  = 2'd0,
		KIND_POP   = 2'd1,
		KIND_CLEAR = 2'd2,
		KIND_SORT  = 2'd3
	} kind_t;

	// request and response payloads
	typedef struct packed {
		kind_t              kind;
		logic [ID_W-1:0]    event_id;
		logic [PRI_W-1:0]   event_priority;
	} req_t;

	typedef struct packed {
		logic               ok;
		logic [ID_W-1:0]    popped_id;
		logic [PRI_W-1:0]   popped_priority;
		logic [CNT_W-1:0]   count;
		logic               empty_res;
	} rsp_t;

	// one stored event
	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [PRI_W-1:0]   pri;
	} entry_t;

	// program steps
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POP,
		ST_SORT_I,
		ST_PIV,
		ST_J,
		ST_END,
		ST_DONE
	} step_t;

	// read address source
	typedef enum logic [1:0] {
		RA_FILLM1,
		RA_I,
		RA_I1,
		RA_J1
	} rd_sel_t;

	// write port use
	typedef enum logic [1:0] {
		WR_NONE,
		WR_PUSH,
		WR_J_SWAP,
		WR_I
	} wr_sel_t;

	// pivot register load
	typedef enum logic [1:0] {
		PV_HOLD,
		PV_LOAD,
		PV_SWAP
	} piv_sel_t;

	// index counter operation
	typedef enum logic [2:0] {
		IX_HOLD,
		IX_CLR_I,
		IX_J_INIT,
		IX_J_INC,
		IX_I_INC
	} idx_op_t;

	// result source
	typedef enum logic [1:0] {
		RES_NONE,
		RES_DISPATCH,
		RES_POP,
		RES_SORT
	} res_sel_t;

	// jump condition
	typedef enum logic [1:0] {
		C_ALWAYS,
		C_KIND,
		C_J_LAST,
		C_I_LAST
	} cond_t;

	// control word
	typedef struct packed {
		logic       accept;
		rd_sel_t    rd;
		wr_sel_t    wr;
		piv_sel_t   piv;
		idx_op_t    idx;
		res_sel_t   res;
		cond_t      cond;
		step_t      tgt;
		step_t      alt;
	} ctrl_t;

	// control store: one word per step
	function automatic ctrl_t ucode(input step_t s);
		ctrl_t w;
		w = '{accept: 1'b0, rd: RA_I, wr: WR_NONE, piv: PV_HOLD, idx: IX_HOLD,
			res: RES_NONE, cond: C_ALWAYS, tgt: ST_IDLE, alt: ST_IDLE};
		case (s)
			ST_IDLE: begin
				w = '{accept: 1'b1, rd: RA_FILLM1, wr: WR_PUSH, piv: PV_HOLD,
					idx: IX_CLR_I, res: RES_DISPATCH, cond: C_KIND,
					tgt: ST_IDLE, alt: ST_IDLE};
			end
			ST_POP: begin
				w = '{accept: 1'b0, rd: RA_I, wr: WR_NONE, piv: PV_HOLD,
					idx: IX_HOLD, res: RES_POP, cond: C_ALWAYS,
					tgt: ST_IDLE, alt: ST_IDLE};
			end
			ST_SORT_I: begin
				w = '{accept: 1'b0, rd: RA_I, wr: WR_NONE, piv: PV_HOLD,
					idx: IX_HOLD, res: RES_NONE, cond: C_ALWAYS,
					tgt: ST_PIV, alt: ST_PIV};
			end
			ST_PIV: begin
				w = '{accept: 1'b0, rd: RA_I1, wr: WR_NONE, piv: PV_LOAD,
					idx: IX_J_INIT, res: RES_NONE, cond: C_ALWAYS,
					tgt: ST_J, alt: ST_J};
			end
			ST_J: begin
				w = '{accept: 1'b0, rd: RA_J1, wr: WR_J_SWAP, piv: PV_SWAP,
					idx: IX_J_INC, res: RES_NONE, cond: C_J_LAST,
					tgt: ST_END, alt: ST_J};
			end
			ST_END: begin
				w = '{accept: 1'b0, rd: RA_I1, wr: WR_I, piv: PV_HOLD,
					idx: IX_I_INC, res: RES_NONE, cond: C_I_LAST,
					tgt: ST_DONE, alt: ST_PIV};
			end
			ST_DONE: begin
				w = '{accept: 1'b0, rd: RA_I, wr: WR_NONE, piv: PV_HOLD,
					idx: IX_HOLD, res: RES_SORT, cond: C_ALWAYS,
					tgt: ST_IDLE, alt: ST_IDLE};
			end
			default: begin
				w = '{accept: 1'b0, rd: RA_I, wr: WR_NONE, piv: PV_HOLD,
					idx: IX_HOLD, res: RES_NONE, cond: C_ALWAYS,
					tgt: ST_IDLE, alt: ST_IDLE};
			end
		endcase
		return w;
	endfunction

endpackage

FILE: rtl/event_stack_with_priority_sort_core.sv
// event_stack_with_priority_sort_core: bounded event stack with in-place sort
// depends on esps_pkg and esps_ram
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | esps_pkg::req_t
//  rsp     | out       | rsp_valid/rsp_stall | esps_pkg::rsp_t
//  cfg     | in        | cfg_wen             | cfg_wdata, capacity in events
//
// push, clear, failed pop and sort of fewer than two events: answered from idle
// pop: via the pop step, which waits on the registered read of the event memory
// sort of n events: a pivot pass per position i, one compare per cycle
//   through the single write port of the memory; no request taken meanwhile
// reset clears the count and sets capacity to 64; the memory is not cleared
// a request is taken only in the idle step with the response register free

module event_stack_with_priority_sort_core #(
	parameter int unsigned DEPTH = esps_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  esps_pkg::req_t                req,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output esps_pkg::rsp_t                rsp,
	input  logic                          cfg_wen,
	input  logic [esps_pkg::CNT_W-1:0]    cfg_wdata
);

	import esps_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

	step_t             step_q, step_d;
	ctrl_t             ctrl;
	logic [CNT_W-1:0]  fill_q, fill_d, fill_m1, cap_q, limit;
	logic [AW-1:0]     i_q, j_q;
	entry_t            pivot_q, rdata, wdata;
	logic [AW-1:0]     raddr, waddr;
	logic              we;
	logic              xfer, out_free, has_room, swap, j_last, i_last;
	logic              res_load;
	rsp_t              res_d, rsp_q;
	logic              rsp_valid_q;

	// handshake and status terms
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign req_stall = !(ctrl.accept && out_free);
	assign xfer     = req_valid && !req_stall;
	assign limit    = (cap_q > DEPTH_C) ? DEPTH_C : cap_q;
	assign has_room = fill_q < limit;
	assign fill_m1  = fill_q - 1'b1;
	assign swap     = rdata.pri < pivot_q.pri;
	assign j_last   = CNT_W'(j_q) == fill_m1;
	assign i_last   = ((CNT_W+1)'(i_q) + (CNT_W+1)'(2)) >= {1'b0, fill_q};

	// control word of the current step
	always_comb begin
		ctrl = ucode(step_q);
	end

	// next step
	always_comb begin
		step_d = ctrl.alt;
		unique case (ctrl.cond)
			C_ALWAYS: step_d = ctrl.tgt;
			C_J_LAST: step_d = j_last ? ctrl.tgt : ctrl.alt;
			C_I_LAST: step_d = i_last ? ctrl.tgt : ctrl.alt;
			C_KIND: begin
				priority if (xfer && req.kind == KIND_POP && fill_q != '0) begin
					step_d = ST_POP;
				end else if (xfer && req.kind == KIND_SORT && fill_q > CNT_W'(1)) begin
					step_d = ST_SORT_I;
				end else begin
					step_d = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	// memory read address
	always_comb begin
		unique case (ctrl.rd)
			RA_FILLM1: raddr = fill_m1[AW-1:0];
			RA_I:      raddr = i_q;
			RA_I1:     raddr = i_q + 1'b1;
			RA_J1:     raddr = j_q + 1'b1;
		endcase
	end

	// memory write port
	always_comb begin
		we    = 1'b0;
		waddr = i_q;
		wdata = pivot_q;
		unique case (ctrl.wr)
			WR_NONE: we = 1'b0;
			WR_PUSH: begin
				we    = xfer && req.kind == KIND_PUSH && has_room;
				waddr = fill_q[AW-1:0];
				wdata = '{id: req.event_id, pri: req.event_priority};
			end
			WR_J_SWAP: begin
				we    = swap;
				waddr = j_q;
			end
			WR_I: we = 1'b1;
		endcase
	end

	esps_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// sort indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
		end else begin
			unique case (ctrl.idx)
				IX_HOLD:   ;
				IX_CLR_I:  i_q <= '0;
				IX_J_INIT: j_q <= i_q + 1'b1;
				IX_J_INC:  j_q <= j_q + 1'b1;
				IX_I_INC:  i_q <= i_q + 1'b1;
				default:   ;
			endcase
		end
	end

	// pivot holds the event bound for position i during its pass
	always_ff @(posedge clk) begin
		unique case (ctrl.piv)
			PV_HOLD: ;
			PV_LOAD: pivot_q <= rdata;
			PV_SWAP: if (swap) pivot_q <= rdata;
			default: ;
		endcase
	end

	// result and count update
	always_comb begin
		res_load = 1'b0;
		fill_d   = fill_q;
		res_d    = '{ok: 1'b0, popped_id: '0, popped_priority: '0,
			count: fill_q, empty_res: 1'b0};
		unique case (ctrl.res)
			RES_NONE: ;
			RES_DISPATCH: begin
				unique case (req.kind)
					KIND_PUSH: begin
						res_load = xfer;
						if (xfer && has_room) begin
							fill_d = fill_q + 1'b1;
						end
						res_d.ok = has_room;
					end
					KIND_POP: begin
						res_load = xfer && fill_q == '0;
					end
					KIND_CLEAR: begin
						res_load = xfer;
						if (xfer) begin
							fill_d = '0;
						end
						res_d.ok = 1'b1;
					end
					KIND_SORT: begin
						res_load = xfer && fill_q <= CNT_W'(1);
						res_d.ok = fill_q != '0;
					end
				endcase
			end
			RES_POP: begin
				res_load              = 1'b1;
				fill_d                = fill_m1;
				res_d.ok              = 1'b1;
				res_d.popped_id       = rdata.id;
				res_d.popped_priority = rdata.pri;
			end
			RES_SORT: begin
				res_load = 1'b1;
				res_d.ok = 1'b1;
			end
		endcase
		res_d.count     = fill_d;
		res_d.empty_res = fill_d == '0;
	end

	// count and capacity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			cap_q  <= CAP_RESET;
		end else begin
			fill_q <= fill_d;
			if (cfg_wen) begin
				cap_q <= cfg_wdata;
			end
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			rsp_q <= res_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= DEPTH_C)
		else $error("event count above depth");

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		xfer |-> step_q == ST_IDLE)
		else $error("request taken outside idle step");

	a_res_slot: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> out_free)
		else $error("response overwrites a pending transfer");

	a_sort_count: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == ST_SORT_I || step_q == ST_PIV || step_q == ST_J ||
		step_q == ST_END || step_q == ST_DONE) |=> $stable(fill_q))
		else $error("count changed during sort");

endmodule

FILE: rtl/esps_ram.sv
// esps_ram: generic single-write, single-read memory with registered read data
// no dependencies
module esps_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
